// File: src/prk_pkg.sv
`default_nettype none
package prk_pkg;

	// graph geometry
	localparam int MAX_PAGES  = 1024;
	localparam int PAGE_BITS  = $clog2(MAX_PAGES);
	localparam int CNT_BITS   = 11;
	localparam int LINK_W     = 64;
	localparam int BIT_BITS   = $clog2(LINK_W);
	localparam int ROW_WORDS  = MAX_PAGES / LINK_W;
	localparam int WIDX_BITS  = $clog2(ROW_WORDS);
	localparam int LINK_AW    = PAGE_BITS + WIDX_BITS;
	localparam int LINK_DEPTH = MAX_PAGES * ROW_WORDS;

	// number formats
	localparam int RANK_BITS = 32;
	localparam int DAMP_BITS = 16;
	localparam int CHG_BITS  = RANK_BITS + 2;
	localparam int ITER_BITS = 16;
	localparam int DEG_BITS  = 11;
	localparam int DIV_BITS  = RANK_BITS + 1;
	localparam int SUM_BITS  = RANK_BITS + PAGE_BITS;
	localparam int PROD_BITS = SUM_BITS + DAMP_BITS;
	localparam int RSUM_BITS = SUM_BITS + 1;

	localparam logic [DEG_BITS-1:0] DEG_MAX = '1;

	// item kinds
	localparam logic [1:0] KIND_LINK  = 2'd0;
	localparam logic [1:0] KIND_RUN   = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	// result kinds
	localparam logic RES_RUN  = 1'b0;
	localparam logic RES_READ = 1'b1;

	// register indexes
	localparam logic [1:0] CFG_PAGES = 2'd0;
	localparam logic [1:0] CFG_DAMP  = 2'd1;
	localparam logic [1:0] CFG_THR   = 2'd2;
	localparam logic [1:0] CFG_LIMIT = 2'd3;

	// register reset values
	localparam logic [CNT_BITS-1:0]  PAGES_RST = 11'd1;
	localparam logic [DAMP_BITS-1:0] DAMP_RST  = 16'd55705;
	localparam logic [CHG_BITS-1:0]  THR_RST   = 34'd42950;
	localparam logic [ITER_BITS-1:0] LIMIT_RST = 16'd1000;

	typedef struct packed {
		logic                go;
		logic [DIV_BITS-1:0] dividend;
		logic [DEG_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: src/prk_ram.sv
`default_nettype none
module prk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: src/prk_div.sv
`default_nettype none
module prk_div import prk_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output      div_rsp_t rsp
);

	localparam int STEP_BITS = $clog2(DIV_BITS + 1);

	logic [STEP_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0]  dvd_q;
	logic [DEG_BITS-1:0]  rem_q;
	logic [DEG_BITS-1:0]  dsr_q;
	logic                 done_q;
	logic [DEG_BITS:0]    rem_sh;
	logic                 fits;
	logic [DEG_BITS:0]    rem_sub;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, dvd_q[DIV_BITS-1]};
		fits    = (rem_sh >= {1'b0, dsr_q});
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				cnt_q <= STEP_BITS'(DIV_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the dividend register from below
	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIV_BITS-2:0], fits};
			rem_q <= fits ? rem_sub[DEG_BITS-1:0] : rem_sh[DEG_BITS-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

endmodule
`default_nettype wire

// File: src/pagerank_power_iteration_unit.sv
`default_nettype none
// Channel   Signals                                   Direction  Handshake
// item      start, kind, from_page, to_page           in         start & !busy
// result    done, result_kind, page_rank, out_degree,  out        done, one cycle
//           iterations_done, converged, total_change
// config    cfg_we, cfg_idx, cfg_data                 in         cfg_we
//
// Link items read, then write, the link word and degree (S_LRD, S_LWR); read items
// read rank and degree and report (S_RRD, S_ROUT). Clear zeroes the link memory,
// one link word per cycle; after reset the same clearing pass runs with busy high.
// A compute does set-up, then per pass a division per page in the shared serial
// divider, per page a bit scan of link words up to word (N-1)/64 and an update.
// Results are registered and shown for one cycle; the receiver cannot stall.
module pagerank_power_iteration_unit import prk_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire logic [1:0]           kind,
	input  wire logic [PAGE_BITS-1:0] from_page,
	input  wire logic [PAGE_BITS-1:0] to_page,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_idx,
	input  wire logic [CHG_BITS-1:0]  cfg_data,
	output      logic                 done,
	output      logic                 result_kind,
	output      logic [RANK_BITS-1:0] page_rank,
	output      logic [DEG_BITS-1:0]  out_degree,
	output      logic [ITER_BITS-1:0] iterations_done,
	output      logic                 converged,
	output      logic [CHG_BITS-1:0]  total_change
);

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_LRD    = 5'd2;
	localparam logic [4:0] S_LWR    = 5'd3;
	localparam logic [4:0] S_RRD    = 5'd4;
	localparam logic [4:0] S_ROUT   = 5'd5;
	localparam logic [4:0] S_CINIT  = 5'd6;
	localparam logic [4:0] S_CINITW = 5'd7;
	localparam logic [4:0] S_CBASE  = 5'd8;
	localparam logic [4:0] S_CBASEW = 5'd9;
	localparam logic [4:0] S_CFILL  = 5'd10;
	localparam logic [4:0] S_PRD    = 5'd11;
	localparam logic [4:0] S_PDIV   = 5'd12;
	localparam logic [4:0] S_PDIVW  = 5'd13;
	localparam logic [4:0] S_RROW   = 5'd14;
	localparam logic [4:0] S_RWORD  = 5'd15;
	localparam logic [4:0] S_SCAN   = 5'd16;
	localparam logic [4:0] S_MUL    = 5'd17;
	localparam logic [4:0] S_UPD    = 5'd18;
	localparam logic [4:0] S_WR     = 5'd19;
	localparam logic [4:0] S_PEND   = 5'd20;

	logic [4:0] state_q;

	// configuration registers
	logic [CNT_BITS-1:0]  pages_q;
	logic [DAMP_BITS-1:0] damp_q;
	logic [CHG_BITS-1:0]  thr_q;
	logic [ITER_BITS-1:0] limit_q;

	// item and loop registers
	logic [PAGE_BITS-1:0] from_q, to_q, i_q, j_q;
	logic [WIDX_BITS-1:0] w_q;
	logic [BIT_BITS-1:0]  b_q;
	logic [LINK_AW-1:0]   clr_q;
	logic [LINK_W-1:0]    word_q;
	logic [RANK_BITS-1:0] init_q, old_q, r_q;
	logic [DIV_BITS-1:0]  base_q;
	logic [SUM_BITS-1:0]  sum_q, chg_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [ITER_BITS-1:0] iter_q;
	logic                 pend_s1;

	// last compute and output registers
	logic [ITER_BITS-1:0] pass_q;
	logic                 conv_q;
	logic [CHG_BITS-1:0]  tchg_q;
	logic                 done_q, rkind_q;
	logic [RANK_BITS-1:0] rank_q;
	logic [DEG_BITS-1:0]  deg_q;

	// memory ports
	logic                 lnk_we;
	logic [LINK_AW-1:0]   lnk_waddr, lnk_raddr;
	logic [LINK_W-1:0]    lnk_wdata, lnk_rdata;
	logic                 deg_we;
	logic [PAGE_BITS-1:0] deg_waddr, deg_raddr;
	logic [DEG_BITS-1:0]  deg_wdata, deg_rdata;
	logic                 cur_we;
	logic [PAGE_BITS-1:0] cur_waddr, cur_raddr;
	logic [RANK_BITS-1:0] cur_wdata, cur_rdata;
	logic                 ctb_we;
	logic [PAGE_BITS-1:0] ctb_raddr;
	logic [RANK_BITS-1:0] ctb_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// derived values
	logic [CNT_BITS-1:0]  neff;
	logic [PAGE_BITS-1:0] nm1;
	logic [WIDX_BITS-1:0] wlast;
	logic                 link_ok;
	logic [PAGE_BITS-1:0] jscan;
	logic                 scan_end;
	logic [RSUM_BITS-1:0] rsum;
	logic [RANK_BITS-1:0] diff;
	logic [CHG_BITS-1:0]  chg_sat;
	logic [ITER_BITS-1:0] iter_n;
	logic                 accept;

	// clamp the page count into its range
	always_comb begin
		if (pages_q == '0) begin
			neff = CNT_BITS'(1);
		end else if (pages_q > CNT_BITS'(MAX_PAGES)) begin
			neff = CNT_BITS'(MAX_PAGES);
		end else begin
			neff = pages_q;
		end
		nm1      = PAGE_BITS'(neff - CNT_BITS'(1));
		wlast    = nm1[PAGE_BITS-1 -: WIDX_BITS];
		link_ok  = ({1'b0, from_page} < neff) && ({1'b0, to_page} < neff)
			&& (from_page != to_page);
		jscan    = {w_q, b_q};
		scan_end = (word_q == '0) || ({1'b0, jscan} >= neff);
		rsum     = RSUM_BITS'(base_q) + RSUM_BITS'(prod_q[PROD_BITS-1:DAMP_BITS]);
		diff     = (r_q >= old_q) ? (r_q - old_q) : (old_q - r_q);
		chg_sat  = (chg_q[SUM_BITS-1:CHG_BITS] != '0) ? '1 : chg_q[CHG_BITS-1:0];
		iter_n   = iter_q + 1'b1;
		accept   = start && (state_q == S_IDLE);
	end

	// memory address and write selection
	always_comb begin
		lnk_we    = (state_q == S_CLR) || (state_q == S_LWR);
		lnk_waddr = (state_q == S_CLR) ? clr_q : {to_q, from_q[PAGE_BITS-1 -: WIDX_BITS]};
		lnk_wdata = (state_q == S_CLR) ? '0
			: (lnk_rdata | (LINK_W'(1) << from_q[BIT_BITS-1:0]));
		lnk_raddr = (state_q == S_RROW) ? {i_q, w_q}
			: {to_q, from_q[PAGE_BITS-1 -: WIDX_BITS]};

		deg_we    = (state_q == S_CLR) || ((state_q == S_LWR) && (deg_rdata != DEG_MAX));
		deg_waddr = (state_q == S_CLR) ? clr_q[PAGE_BITS-1:0] : from_q;
		deg_wdata = (state_q == S_CLR) ? '0 : (deg_rdata + 1'b1);
		deg_raddr = (state_q == S_PRD) ? j_q : from_q;

		cur_we    = (state_q == S_CFILL) || (state_q == S_WR);
		cur_waddr = i_q;
		cur_wdata = (state_q == S_CFILL) ? init_q : r_q;
		cur_raddr = (state_q == S_RRD) ? from_q : ((state_q == S_PRD) ? j_q : i_q);

		ctb_we    = (state_q == S_PDIVW) && div_rsp.done;
		ctb_raddr = jscan;
	end

	// divider operand selection
	always_comb begin
		div_req.go       = (state_q == S_CINIT) || (state_q == S_CBASE) || (state_q == S_PDIV);
		div_req.divisor  = neff;
		div_req.dividend = DIV_BITS'(1) << RANK_BITS;
		if (state_q == S_CBASE) begin
			div_req.dividend = {(17'h10000 - {1'b0, damp_q}), {(RANK_BITS - DAMP_BITS){1'b0}}};
		end else if (state_q == S_PDIV) begin
			div_req.dividend = {1'b0, cur_rdata};
			if (deg_rdata != '0) begin
				div_req.divisor = deg_rdata;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= PAGES_RST;
			damp_q  <= DAMP_RST;
			thr_q   <= THR_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PAGES: pages_q <= cfg_data[CNT_BITS-1:0];
				CFG_DAMP:  damp_q  <= cfg_data[DAMP_BITS-1:0];
				CFG_THR:   thr_q   <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data[ITER_BITS-1:0];
				default:   pages_q <= pages_q;
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			pass_q  <= '0;
			conv_q  <= 1'b0;
			tchg_q  <= '0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LINK_AW'(LINK_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_LINK:  state_q <= link_ok ? S_LRD : S_IDLE;
							KIND_RUN:   state_q <= S_CINIT;
							KIND_READ:  state_q <= S_RRD;
							KIND_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_LRD:  state_q <= S_LWR;
				S_LWR:  state_q <= S_IDLE;
				S_RRD:  state_q <= S_ROUT;
				S_ROUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CINIT:  state_q <= S_CINITW;
				S_CINITW: begin
					if (div_rsp.done) begin
						state_q <= S_CBASE;
					end
				end
				S_CBASE:  state_q <= S_CBASEW;
				S_CBASEW: begin
					if (div_rsp.done) begin
						state_q <= S_CFILL;
					end
				end
				S_CFILL: begin
					if (i_q == nm1) begin
						state_q <= S_PRD;
					end
				end
				S_PRD:  state_q <= S_PDIV;
				S_PDIV: state_q <= S_PDIVW;
				S_PDIVW: begin
					if (div_rsp.done) begin
						state_q <= (j_q == nm1) ? S_RROW : S_PRD;
					end
				end
				S_RROW:  state_q <= S_RWORD;
				S_RWORD: state_q <= S_SCAN;
				S_SCAN: begin
					if (scan_end) begin
						state_q <= (w_q == wlast) ? S_MUL : S_RROW;
					end else begin
						pend_s1 <= word_q[0];
					end
				end
				S_MUL: state_q <= S_UPD;
				S_UPD: state_q <= S_WR;
				S_WR:  state_q <= (i_q == nm1) ? S_PEND : S_RROW;
				S_PEND: begin
					if ((iter_n < limit_q) && (chg_sat >= thr_q)) begin
						state_q <= S_PRD;
					end else begin
						pass_q  <= iter_n;
						conv_q  <= (chg_sat < thr_q);
						tchg_q  <= chg_sat;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			sum_q <= sum_q + SUM_BITS'(ctb_rdata);
		end
		case (state_q)
			S_IDLE: begin
				from_q <= from_page;
				to_q   <= to_page;
				iter_q <= '0;
			end
			S_ROUT: begin
				rkind_q <= RES_READ;
				rank_q  <= cur_rdata;
				deg_q   <= deg_rdata;
			end
			S_CINITW: begin
				init_q <= div_rsp.quot[RANK_BITS] ? '1 : div_rsp.quot[RANK_BITS-1:0];
			end
			S_CBASEW: begin
				base_q <= div_rsp.quot;
				i_q    <= '0;
			end
			S_CFILL: begin
				i_q   <= i_q + 1'b1;
				j_q   <= '0;
				chg_q <= '0;
			end
			S_PDIVW: begin
				if (div_rsp.done) begin
					j_q   <= j_q + 1'b1;
					i_q   <= '0;
					w_q   <= '0;
					sum_q <= '0;
				end
			end
			S_RWORD: begin
				word_q <= lnk_rdata;
				b_q    <= '0;
			end
			S_SCAN: begin
				if (scan_end) begin
					w_q <= w_q + 1'b1;
				end else begin
					word_q <= word_q >> 1;
					b_q    <= b_q + 1'b1;
				end
			end
			S_MUL: prod_q <= PROD_BITS'(sum_q) * PROD_BITS'(damp_q);
			S_UPD: begin
				old_q <= cur_rdata;
				r_q   <= (rsum[RSUM_BITS-1:RANK_BITS] != '0) ? '1 : rsum[RANK_BITS-1:0];
			end
			S_WR: begin
				chg_q <= chg_q + SUM_BITS'(diff);
				i_q   <= i_q + 1'b1;
				w_q   <= '0;
				sum_q <= '0;
			end
			S_PEND: begin
				iter_q  <= iter_n;
				j_q     <= '0;
				chg_q   <= '0;
				rkind_q <= RES_RUN;
				rank_q  <= '0;
				deg_q   <= '0;
			end
			default: begin
			end
		endcase
	end

	prk_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.raddr (lnk_raddr),
		.rdata (lnk_rdata)
	);

	prk_ram #(.WIDTH(DEG_BITS), .DEPTH(MAX_PAGES)) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.raddr (deg_raddr),
		.rdata (deg_rdata)
	);

	prk_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_PAGES)) u_rank_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	prk_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_PAGES)) u_share_ram (
		.clk   (clk),
		.we    (ctb_we),
		.waddr (j_q),
		.wdata (div_rsp.quot[RANK_BITS-1:0]),
		.raddr (ctb_raddr),
		.rdata (ctb_rdata)
	);

	prk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// drive the ports
	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign result_kind     = rkind_q;
	assign page_rank       = rank_q;
	assign out_degree      = deg_q;
	assign iterations_done = pass_q;
	assign converged       = conv_q;
	assign total_change    = tchg_q;

endmodule
`default_nettype wire

// File: sim/pagerank_power_iteration_unit_tb.sv
`timescale 1ns / 1ps
module pagerank_power_iteration_unit_tb;
	import prk_pkg::*;

	localparam int  CYCLE_LIMIT = 4000000;
	localparam int  MAX_SHOWN   = 10;

	typedef struct packed {
		logic                 rkind;
		logic [RANK_BITS-1:0] rank;
		logic [DEG_BITS-1:0]  deg;
		logic [ITER_BITS-1:0] iters;
		logic                 conv;
		logic [CHG_BITS-1:0]  chg;
	} rank_answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           kind;
	logic [PAGE_BITS-1:0] from_page;
	logic [PAGE_BITS-1:0] to_page;
	logic                 cfg_we;
	logic [1:0]           cfg_idx;
	logic [CHG_BITS-1:0]  cfg_data;
	logic                 done;
	logic                 result_kind;
	logic [RANK_BITS-1:0] page_rank;
	logic [DEG_BITS-1:0]  out_degree;
	logic [ITER_BITS-1:0] iterations_done;
	logic                 converged;
	logic [CHG_BITS-1:0]  total_change;

	// shadow of the graph, the ranks and the registers
	logic [MAX_PAGES-1:0] in_links [MAX_PAGES];
	logic [DEG_BITS-1:0]  degree [MAX_PAGES];
	logic [RANK_BITS-1:0] rank_now [MAX_PAGES];
	logic [RANK_BITS-1:0] rank_prev [MAX_PAGES];
	logic [ITER_BITS-1:0] last_iters;
	logic                 last_conv;
	logic [CHG_BITS-1:0]  last_chg;
	logic [CNT_BITS-1:0]  reg_pages;
	logic [DAMP_BITS-1:0] reg_damp;
	logic [CHG_BITS-1:0]  reg_thr;
	logic [ITER_BITS-1:0] reg_limit;
	int                   ranked_pages;

	rank_answer_t pending_answers [$];
	int  mismatches;
	int  answers_seen;
	int  items_sent;
	int  runs_sent;
	int  cycles;
	bit  no_gaps;

	pagerank_power_iteration_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.from_page(from_page), .to_page(to_page), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .done(done), .result_kind(result_kind),
		.page_rank(page_rank), .out_degree(out_degree),
		.iterations_done(iterations_done), .converged(converged),
		.total_change(total_change)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// end the run if the block stops answering
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pages_in_use();
		if (reg_pages < 1) return 1;
		if (reg_pages > MAX_PAGES) return MAX_PAGES;
		return int'(reg_pages);
	endfunction

	// damped power iteration over the shadow graph
	function automatic void iterate_ranks();
		int n;
		longint unsigned init, base, thr, sum, r, chg, a, p;
		int iter, lim;
		n = pages_in_use();
		init = 64'h1_0000_0000 / n;
		if (init > 64'hFFFF_FFFF) init = 64'hFFFF_FFFF;
		base = ((64'd65536 - reg_damp) << 16) / n;
		thr = reg_thr;
		lim = reg_limit;
		iter = 0;
		for (int i = 0; i < n; i++) rank_now[i] = init[31:0];
		do begin
			for (int i = 0; i < n; i++) rank_prev[i] = rank_now[i];
			for (int i = 0; i < n; i++) begin
				sum = 0;
				for (int j = 0; j < n; j++)
					if (in_links[i][j])
						sum += (degree[j] != 0) ? rank_prev[j] / degree[j] : rank_prev[j] / n;
				r = base + (sum >> 16) * reg_damp + (((sum & 64'hFFFF) * reg_damp) >> 16);
				if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
				rank_now[i] = r[31:0];
			end
			chg = 0;
			for (int i = 0; i < n; i++) begin
				a = rank_now[i];
				p = rank_prev[i];
				chg += (a >= p) ? a - p : p - a;
			end
			if (chg > 64'h3_FFFF_FFFF) chg = 64'h3_FFFF_FFFF;
			iter++;
		end while (iter < lim && chg >= thr);
		last_iters = iter[15:0];
		last_chg = chg[CHG_BITS-1:0];
		last_conv = chg < thr;
		if (n > ranked_pages) ranked_pages = n;
	endfunction

	// apply one accepted beat to the shadow and queue its answer
	function automatic void predict_item(logic [1:0] k, int src, int dst);
		rank_answer_t ans;
		int n;
		n = pages_in_use();
		case (k)
			KIND_LINK: begin
				if (src < n && dst < n && src != dst) begin
					in_links[dst][src] = 1'b1;
					if (degree[src] != DEG_MAX) degree[src]++;
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < MAX_PAGES; i++) begin
					in_links[i] = '0;
					degree[i] = '0;
				end
			end
			default: begin
				if (k == KIND_RUN) begin
					iterate_ranks();
					runs_sent++;
					ans.rkind = RES_RUN;
					ans.rank = '0;
					ans.deg = '0;
				end else begin
					ans.rkind = RES_READ;
					ans.rank = rank_now[src];
					ans.deg = degree[src];
				end
				ans.iters = last_iters;
				ans.conv = last_conv;
				ans.chg = last_chg;
				pending_answers.push_back(ans);
			end
		endcase
	endfunction

	// compare each answer beat with the oldest expectation
	always @(posedge clk) begin
		rank_answer_t want;
		if (arst_n && done) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected answer beat, kind %0d", result_kind);
			end else begin
				want = pending_answers.pop_front();
				if (result_kind !== want.rkind || page_rank !== want.rank ||
						out_degree !== want.deg || iterations_done !== want.iters ||
						converged !== want.conv || total_change !== want.chg) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: exp k%0d r%h d%0d i%0d c%0d ch%h got k%0d r%h d%0d i%0d c%0d ch%h",
							want.rkind, want.rank, want.deg, want.iters, want.conv, want.chg,
							result_kind, page_rank, out_degree, iterations_done, converged,
							total_change);
				end
			end
		end
	end

	// send one beat, at times with a random gap ahead of it
	task automatic send_item(logic [1:0] k, int src, int dst);
		if (!no_gaps && $urandom_range(99) < 15)
			repeat ($urandom_range(1, 8)) @(negedge clk);
		@(negedge clk);
		start = 1'b1;
		kind = k;
		from_page = src[PAGE_BITS-1:0];
		to_page = dst[PAGE_BITS-1:0];
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		predict_item(k, src, dst);
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	// wait until the block has nothing left in hand
	task automatic wait_idle();
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CHG_BITS-1:0] val);
		wait_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_PAGES: reg_pages = val[CNT_BITS-1:0];
			CFG_DAMP:  reg_damp = val[DAMP_BITS-1:0];
			CFG_THR:   reg_thr = val;
			default:   reg_limit = val[ITER_BITS-1:0];
		endcase
	endtask

	task automatic set_regs(int pages, int damp, logic [CHG_BITS-1:0] thr, int lim);
		write_reg(CFG_PAGES, CHG_BITS'(pages));
		write_reg(CFG_DAMP, CHG_BITS'(damp));
		write_reg(CFG_THR, thr);
		write_reg(CFG_LIMIT, CHG_BITS'(lim));
	endtask

	function automatic int written_page();
		return $urandom_range(ranked_pages - 1);
	endfunction

	// run on reset values: single page, default damping and limit
	task automatic test_reset_defaults();
		send_item(KIND_LINK, 0, 0);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 0, 0);
	endtask

	// out-of-range, self and duplicate links; the far corner of the page range
	task automatic test_link_cases();
		set_regs(6, 0, '1, 0);
		send_item(KIND_LINK, 0, 1);
		send_item(KIND_LINK, 0, 1);
		send_item(KIND_LINK, 2, 2);
		send_item(KIND_LINK, 6, 1);
		send_item(KIND_LINK, 1, 1023);
		send_item(KIND_LINK, 3, 4);
		send_item(KIND_LINK, 4, 0);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_READ, 5, 0);
		set_regs(5, 65535, '0, 4);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 4, 0);
		send_item(KIND_READ, 5, 0);
		// out-of-range page count acts as the nearest bound
		set_regs(0, 32768, 34'd1000, 3);
		send_item(KIND_RUN, 0, 0);
		set_regs(2047, 55705, '1, 1);
		send_item(KIND_LINK, 1023, 0);
		send_item(KIND_LINK, 0, 1023);
		send_item(KIND_LINK, 512, 7);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 1023, 0);
		send_item(KIND_READ, 0, 0);
		set_regs(4, 40000, 34'd5000, 65535);
		send_item(KIND_RUN, 0, 0);
	endtask

	// out-degree stops at its maximum
	task automatic test_degree_saturation();
		no_gaps = 1'b1;
		for (int i = 0; i < DEG_MAX + 3; i++) send_item(KIND_LINK, 2, 3);
		no_gaps = 1'b0;
		send_item(KIND_READ, 2, 0);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 3, 0);
	endtask

	// clear drops links and degrees, keeps ranks and the last run summary
	task automatic test_clear();
		send_item(KIND_CLEAR, 0, 0);
		send_item(KIND_READ, 2, 0);
		send_item(KIND_READ, 1023, 0);
	endtask

	// random graphs: mostly well-formed links, then a run and some reads
	task automatic test_random_traffic();
		int n, links, reads, round;
		int src, dst;
		logic [CHG_BITS-1:0] thr;
		round = 0;
		while (round < 3 || items_sent < 1950) begin
			no_gaps = (round >= 20 && round < 35);
			if (round % 3 == 0) begin
				case ($urandom_range(2))
					0: thr = '0;
					1: thr = CHG_BITS'($urandom_range(200000));
					default: thr = {2'($urandom_range(3)), $urandom};
				endcase
				set_regs($urandom_range(2, 12), $urandom_range(65535), thr,
					$urandom_range(1, 10));
			end
			if ($urandom_range(29) == 0) send_item(KIND_CLEAR, 0, 0);
			n = pages_in_use();
			links = $urandom_range(3, 30);
			for (int i = 0; i < links; i++) begin
				if ($urandom_range(99) < 85) begin
					src = $urandom_range(n - 1);
					dst = (src + $urandom_range(1, n - 1)) % n;
				end else begin
					src = $urandom_range(1023);
					dst = ($urandom_range(1)) ? src : $urandom_range(1023);
				end
				send_item(KIND_LINK, src, dst);
			end
			send_item(KIND_RUN, 0, 0);
			reads = $urandom_range(3, 10);
			for (int i = 0; i < reads; i++) send_item(KIND_READ, written_page(), $urandom_range(1023));
			round++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_LINK;
		from_page = '0;
		to_page = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_PAGES;
		cfg_data = '0;
		no_gaps = 1'b0;
		mismatches = 0;
		answers_seen = 0;
		items_sent = 0;
		runs_sent = 0;
		cycles = 0;
		ranked_pages = 0;
		for (int i = 0; i < MAX_PAGES; i++) begin
			in_links[i] = '0;
			degree[i] = '0;
			rank_now[i] = '0;
			rank_prev[i] = '0;
		end
		last_iters = '0;
		last_conv = 1'b0;
		last_chg = '0;
		reg_pages = PAGES_RST;
		reg_damp = DAMP_RST;
		reg_thr = THR_RST;
		reg_limit = LIMIT_RST;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_link_cases();
		test_degree_saturation();
		test_clear();
		test_random_traffic();

		while (pending_answers.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d beats including %0d rank runs; checked %0d answer beats",
			items_sent, runs_sent, answers_seen);
		$display("page counts 1 to 1024, damping and threshold extremes, %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
src/prk_pkg.sv
src/prk_ram.sv
src/prk_div.sv
src/pagerank_power_iteration_unit.sv
sim/pagerank_power_iteration_unit_tb.sv
